// ===== sv/sha1md_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 digest block.
package sha1md_pkg;

    // Input word: one message byte with its flags
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       is_last;
    } t_in;

    // Output word: one digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // Five chaining words, element 0 is H0
    typedef logic [4:0][31:0] t_chain;

    // Byte push into the schedule buffer
    typedef struct packed {
        logic       valid;
        logic       word_end;
        logic [7:0] data;
    } t_push;

    // Schedule control from the round unit
    typedef struct packed {
        logic shift;
        logic early;
    } t_sched_ctl;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } t_state;

    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam logic [6:0] LAST_ROUND  = 7'(ROUNDS - 1);
    localparam logic [6:0] EARLY_LIMIT = 7'(BLOCK_WORDS);

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [2:0] LAST_IDX  = 3'd4;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam t_chain CHAIN_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Round constant for one of the four 20-round phases
    function automatic logic [31:0] round_k(input logic [1:0] phase);
        logic [31:0] k;
        unique case (phase)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    // Round function for one of the four phases
    function automatic logic [31:0] round_f(input logic [1:0] phase,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        unique case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/sha1md_sched.sv =====
// Message buffer and rolling message schedule as a 16-word shift line.
module sha1md_sched (
    input  logic                   i_clk,
    input  sha1md_pkg::t_push      i_push,
    input  sha1md_pkg::t_sched_ctl i_ctl,
    output logic [31:0]            o_w
);

    logic [23:0] r_acc;
    logic [31:0] r_win [16];
    logic [31:0] w_exp;
    logic [31:0] w_in;

    // Select the schedule word for this round
    always_comb begin
        w_exp = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        o_w   = i_ctl.early ? r_win[0] : {w_exp[30:0], w_exp[31]};
        w_in  = i_push.valid ? {r_acc, i_push.data} : o_w;
    end

    // Pack bytes into words and shift the window
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_acc <= {r_acc[15:0], i_push.data};
        end
        if ((i_push.valid && i_push.word_end) || i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_in;
        end
    end

endmodule

// ===== sv/sha1md_compress.sv =====
// Round unit: one SHA-1 round per cycle for all 80 rounds, then chaining add.
module sha1md_compress (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_restart,
    input  logic [31:0]            i_w,
    output sha1md_pkg::t_sched_ctl o_sched,
    output sha1md_pkg::t_chain     o_chain,
    output logic                   o_done
);

    logic [31:0]        r_a, r_b, r_c, r_d, r_e;
    logic [6:0]         r_t;
    logic               r_busy;
    logic               r_fin;
    sha1md_pkg::t_chain r_h;
    logic [1:0]         phase;
    logic [31:0]        n_a;

    // Pick phase and compute the new a
    always_comb begin
        if (r_t < 7'd20) begin
            phase = 2'd0;
        end else if (r_t < 7'd40) begin
            phase = 2'd1;
        end else if (r_t < 7'd60) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
        n_a = {r_a[26:0], r_a[31:27]} + sha1md_pkg::round_f(phase, r_b, r_c, r_d)
            + r_e + sha1md_pkg::round_k(phase) + i_w;
    end

    assign o_sched.shift = r_busy;
    assign o_sched.early = r_t < sha1md_pkg::EARLY_LIMIT;
    assign o_chain       = r_h;
    assign o_done        = r_fin;

    // Sequence the rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_t    <= '0;
        end else begin
            r_fin <= r_busy && (r_t == sha1md_pkg::LAST_ROUND);
            if (i_start) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (r_busy) begin
                r_t <= r_t + 7'd1;
                if (r_t == sha1md_pkg::LAST_ROUND) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Advance the working variables
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_busy) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Fold the block result into the chaining words; reset or restart loads the initial values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_h <= sha1md_pkg::CHAIN_INIT;
        end else if (r_fin) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

endmodule

// ===== sv/sha1_message_digest.sv =====
// SHA-1 digest of a byte stream: one byte per input word, five digest words out.
//
// Input channel: i_in_valid / o_in_stall with i_in_word (msg_byte, has_byte,
// is_last). A word is taken when valid is high and stall is low. A word with
// has_byte low adds no byte; is_last ends the message, so an empty message is
// a single word with has_byte low and is_last high.
// Output channel: o_out_valid / i_out_stall with o_out_word carrying
// digest_word, word_index 0..4 and last_word on the fifth word.
// Timing: a byte that does not complete a 64-byte block is taken without a
// stall. A byte that completes a block adds one compression (80 rounds at
// one round per cycle on the shared round unit, plus start and chaining add).
// The final word then pushes padding and length one byte per cycle outside
// compressions (up to 64 bytes, or up to 72 when a second block is needed,
// with a pause without a push before the length) with one or two more
// compressions, after which the five digest words are offered.
// The input is stalled until the last digest word has been taken; a stall
// on the output holds the current digest word.
// Reset puts the chaining words to the SHA-1 initial values and clears the
// byte fill and message length; after the digest the same happens.
module sha1_message_digest (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sha1md_pkg::t_in   i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sha1md_pkg::t_out  o_out_word
);

    sha1md_pkg::t_state     r_state, n_state;
    sha1md_pkg::t_state     r_after, n_after;
    logic [5:0]             r_fill;
    logic [60:0]            r_count;
    logic [2:0]             r_idx;

    sha1md_pkg::t_push      push;
    sha1md_pkg::t_sched_ctl sched_ctl;
    sha1md_pkg::t_chain     chain;
    logic [31:0]            w;
    logic                   comp_done;
    logic                   start;
    logic                   restart;
    logic                   count_inc;
    logic                   in_acc;
    logic                   out_acc;
    logic [63:0]            bit_len;
    logic [7:0]             len_byte;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Pick the length byte for the current fill position
    always_comb begin
        bit_len  = {r_count, 3'b000};
        len_byte = 8'(bit_len >> {~r_fill[2:0], 3'b000});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.has_byte && r_fill == sha1md_pkg::FILL_LAST) begin
                        n_state = sha1md_pkg::ST_COMP;
                        n_after = i_in_word.is_last ? sha1md_pkg::ST_PAD80
                                                    : sha1md_pkg::ST_IDLE;
                    end else if (i_in_word.is_last) begin
                        n_state = sha1md_pkg::ST_PAD80;
                    end
                end
            end
            sha1md_pkg::ST_COMP: begin
                if (comp_done) begin
                    n_state = r_after;
                end
            end
            sha1md_pkg::ST_PAD80: begin
                if (r_fill == sha1md_pkg::FILL_LAST) begin
                    n_state = sha1md_pkg::ST_COMP;
                    n_after = sha1md_pkg::ST_ZERO;
                end else begin
                    n_state = sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_ZERO: begin
                if (r_fill == sha1md_pkg::LEN_START) begin
                    n_state = sha1md_pkg::ST_LEN;
                end else if (r_fill == sha1md_pkg::FILL_LAST) begin
                    n_state = sha1md_pkg::ST_COMP;
                    n_after = sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_LEN: begin
                if (r_fill == sha1md_pkg::FILL_LAST) begin
                    n_state = sha1md_pkg::ST_COMP;
                    n_after = sha1md_pkg::ST_OUT;
                end
            end
            sha1md_pkg::ST_OUT: begin
                if (out_acc && r_idx == sha1md_pkg::LAST_IDX) begin
                    n_state = sha1md_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        push.valid  = 1'b0;
        push.data   = 8'h00;
        count_inc   = 1'b0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                push.valid = i_in_valid && i_in_word.has_byte;
                push.data  = i_in_word.msg_byte;
                count_inc  = push.valid;
            end
            sha1md_pkg::ST_PAD80: begin
                push.valid = 1'b1;
                push.data  = sha1md_pkg::PAD_BYTE;
            end
            sha1md_pkg::ST_ZERO: begin
                push.valid = r_fill != sha1md_pkg::LEN_START;
            end
            sha1md_pkg::ST_LEN: begin
                push.valid = 1'b1;
                push.data  = len_byte;
            end
            sha1md_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                push.valid = 1'b0;
            end
        endcase
        push.word_end = r_fill[1:0] == 2'b11;
        start         = push.valid && r_fill == sha1md_pkg::FILL_LAST;
        restart       = r_state == sha1md_pkg::ST_OUT && !i_out_stall
                        && r_idx == sha1md_pkg::LAST_IDX;
    end

    assign o_out_word.digest_word = chain[r_idx];
    assign o_out_word.word_index  = r_idx;
    assign o_out_word.last_word   = r_idx == sha1md_pkg::LAST_IDX;

    // Hold sequencer state, fill, length and output position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::ST_IDLE;
            r_after <= sha1md_pkg::ST_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            if (restart) begin
                r_fill  <= '0;
                r_count <= '0;
            end else begin
                if (push.valid) begin
                    r_fill <= r_fill + 6'd1;
                end
                if (count_inc) begin
                    r_count <= r_count + 61'd1;
                end
            end
            if (out_acc) begin
                r_idx <= restart ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    sha1md_sched u_sched (
        .i_clk  (i_clk),
        .i_push (push),
        .i_ctl  (sched_ctl),
        .o_w    (w)
    );

    sha1md_compress u_compress (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_restart (restart),
        .i_w       (w),
        .o_sched   (sched_ctl),
        .o_chain   (chain),
        .o_done    (comp_done)
    );

    // Digest is never offered while input is open
    a_out_blocks_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("digest offered while input open");

    // No byte enters the buffer while the round unit runs
    a_no_push_in_comp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1md_pkg::ST_COMP) |-> !push.valid)
        else $error("byte pushed during compression");

    // Digest starts at word zero
    a_first_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (r_idx == 3'd0))
        else $error("digest does not start at word zero");

    // Length field starts at byte 56 of the block
    a_len_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1md_pkg::ST_LEN && $past(r_state) != sha1md_pkg::ST_LEN)
        |-> (r_fill == sha1md_pkg::LEN_START))
        else $error("length field misaligned");

endmodule
